FILE: rtl/core/sharx_pkg.sv
// ---------------------------------------------------------------------------
// sharx_pkg: shared types and constants of the string hash
// Chunk geometry, rotation amounts, fold shifts and the mix unit command set.
// ---------------------------------------------------------------------------
package sharx_pkg;

  localparam int unsigned CHUNK_LEN    = 12;
  localparam int unsigned SLOT_W       = $clog2(CHUNK_LEN);
  localparam int unsigned PREFIX_LIMIT = 32;
  localparam int unsigned ROT_A        = 14;
  localparam int unsigned ROT_B        = 11;
  localparam int unsigned ROT_H        = 25;
  localparam int unsigned FOLD_SHL     = 5;
  localparam int unsigned FOLD_SHR     = 2;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_START,
    OP_ADD,
    OP_MIX_A,
    OP_MIX_B,
    OP_MIX_H,
    OP_FOLD_LOAD,
    OP_FOLD_STEP
  } arx_op_e;

  typedef struct packed {
    arx_op_e     op;
    logic [31:0] len;
  } arx_cmd_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [7:0]        data;
  } chunk_wr_t;

  function automatic logic [31:0] rotr32(input logic [31:0] x, input int unsigned s);
    rotr32 = (x >> s) | (x << (32 - s));
  endfunction

endpackage

FILE: rtl/core/string_hash_arx_prefix_top.sv
// ---------------------------------------------------------------------------
// string_hash_arx_prefix_top: streaming 32-bit string hash
// ARX-mixed 12-byte prefix chunks, shift-add-xor fold over the tail bytes.
// ---------------------------------------------------------------------------
//  channel  | dir | tdata                          | tuser                 | tlast
//  s_axis   | in  | [7:0] data_byte, [39:8] length | [0] first, [1] empty  | last
//  m_axis   | out | [31:0] hash_value              | [0] length_error      | -
//
//  A byte is taken only in the idle state. A byte that completes a chunk then
//  runs an add and three mix steps on the a/b/h registers. A last byte then
//  loads the fold and takes one fold step per cycle for each tail byte held
//  (0..32), paced by the tail memory read port. An empty string goes to the result.
//  Input is taken while a result waits on m_axis; a new result waits for it.
//  No clearing pass after reset; the block is ready in the first cycle.
module string_hash_arx_prefix_top import sharx_pkg::*; #(
  parameter int unsigned TAIL_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [7:0] data_byte, [39:8] string_length
  input  logic [1:0]  s_axis_tuser,   // [0] first_item, [1] empty_string
  input  logic        s_axis_tlast,   // last_item
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] hash_value
  output logic [0:0]  m_axis_tuser    // [0] length_error
);

  localparam int unsigned AW = $clog2(TAIL_DEPTH);
  localparam int unsigned CW = $clog2(TAIL_DEPTH + 1);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_ADD    = 8'b0000_0010,
    ST_MIXA   = 8'b0000_0100,
    ST_MIXB   = 8'b0000_1000,
    ST_MIXH   = 8'b0001_0000,
    ST_FLOAD  = 8'b0010_0000,
    ST_FOLD   = 8'b0100_0000,
    ST_RESULT = 8'b1000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [31:0]       rem_q, rem_d;
  logic [31:0]       count_q, count_d;
  logic [31:0]       decl_q, decl_d;
  logic              tail_q, tail_d;
  logic [CW-1:0]     tcnt_q, tcnt_d;
  logic              pend_last_q, pend_last_d;
  logic              pend_empty_q, pend_empty_d;
  logic              empty_err_q, empty_err_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic              out_valid_q, out_valid_d;
  logic [31:0]       out_hash_q, out_hash_d;
  logic              out_err_q, out_err_d;

  logic              accept;
  logic [7:0]        in_byte;
  logic [31:0]       in_len;
  logic              in_first, in_empty;
  logic [SLOT_W-1:0] eff_slot;
  logic [31:0]       eff_rem, eff_count;
  logic              eff_tail;
  logic [CW-1:0]     eff_tcnt;
  logic              prefix_byte;
  logic [CW-1:0]     tcnt_dec;

  arx_cmd_t          cmd;
  chunk_wr_t         chunk_wr;
  logic              mem_wr_en, mem_rd_en;
  logic [AW-1:0]     mem_wr_addr, mem_rd_addr;
  logic [7:0]        mem_rd_data;
  logic [31:0]       fold;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign in_byte       = s_axis_tdata[7:0];
  assign in_len        = s_axis_tdata[39:8];
  assign in_first      = s_axis_tuser[0];
  assign in_empty      = s_axis_tuser[1];

  // a first byte sees the freshly started string
  assign eff_slot  = in_first ? '0 : slot_q;
  assign eff_rem   = in_first ? in_len : rem_q;
  assign eff_count = in_first ? '0 : count_q;
  assign eff_tail  = in_first ? 1'b0 : tail_q;
  assign eff_tcnt  = in_first ? '0 : tcnt_q;

  // a chunk opens only with 32 or more declared bytes left; once in the
  // tail the string stays there
  assign prefix_byte = !eff_tail &&
                       ((eff_slot != '0) || (eff_rem >= 32'(PREFIX_LIMIT)));
  assign tcnt_dec    = tcnt_q - CW'(1);

  always_comb begin
    state_d      = state_q;
    slot_d       = slot_q;
    rem_d        = rem_q;
    count_d      = count_q;
    decl_d       = decl_q;
    tail_d       = tail_q;
    tcnt_d       = tcnt_q;
    pend_last_d  = pend_last_q;
    pend_empty_d = pend_empty_q;
    empty_err_d  = empty_err_q;
    idx_d        = idx_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_hash_d   = out_hash_q;
    out_err_d    = out_err_q;
    cmd.op       = OP_IDLE;
    cmd.len      = in_len;
    chunk_wr.en   = 1'b0;
    chunk_wr.slot = eff_slot;
    chunk_wr.data = in_byte;
    mem_wr_en    = 1'b0;
    mem_wr_addr  = eff_tcnt[AW-1:0];
    mem_rd_en    = 1'b0;
    mem_rd_addr  = idx_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_empty) begin
            cmd.op       = OP_START;
            cmd.len      = '0;
            slot_d       = '0;
            rem_d        = '0;
            count_d      = '0;
            decl_d       = '0;
            tail_d       = 1'b0;
            tcnt_d       = '0;
            pend_empty_d = 1'b1;
            empty_err_d  = (in_len != '0);
            state_d      = ST_RESULT;
          end else begin
            if (in_first) begin
              cmd.op = OP_START;
              decl_d = in_len;
            end
            pend_empty_d = 1'b0;
            count_d = (eff_count == '1) ? eff_count : eff_count + 32'd1;
            slot_d  = eff_slot;
            rem_d   = eff_rem;
            tail_d  = eff_tail;
            tcnt_d  = eff_tcnt;
            if (prefix_byte) begin
              chunk_wr.en = 1'b1;
              rem_d       = eff_rem - 32'd1;
              if (eff_slot == SLOT_W'(CHUNK_LEN - 1)) begin
                slot_d      = '0;
                pend_last_d = s_axis_tlast;
                state_d     = ST_ADD;
              end else begin
                slot_d = eff_slot + SLOT_W'(1);
                if (s_axis_tlast) begin
                  state_d = ST_FLOAD;
                end
              end
            end else begin
              tail_d = 1'b1;
              if (eff_tcnt < CW'(TAIL_DEPTH)) begin
                mem_wr_en = 1'b1;
                tcnt_d    = eff_tcnt + CW'(1);
              end
              if (s_axis_tlast) begin
                state_d = ST_FLOAD;
              end
            end
          end
        end
      end
      ST_ADD: begin
        cmd.op  = OP_ADD;
        state_d = ST_MIXA;
      end
      ST_MIXA: begin
        cmd.op  = OP_MIX_A;
        state_d = ST_MIXB;
      end
      ST_MIXB: begin
        cmd.op  = OP_MIX_B;
        state_d = ST_MIXH;
      end
      ST_MIXH: begin
        cmd.op  = OP_MIX_H;
        state_d = pend_last_q ? ST_FLOAD : ST_IDLE;
      end
      ST_FLOAD: begin
        cmd.op = OP_FOLD_LOAD;
        if (tcnt_q == '0) begin
          state_d = ST_RESULT;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = tcnt_dec[AW-1:0];
          idx_d       = tcnt_dec[AW-1:0];
          state_d     = ST_FOLD;
        end
      end
      ST_FOLD: begin
        // fold walks the tail from the newest byte back to the oldest
        cmd.op = OP_FOLD_STEP;
        if (idx_q == '0) begin
          state_d = ST_RESULT;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = idx_q - AW'(1);
          idx_d       = idx_q - AW'(1);
        end
      end
      ST_RESULT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_hash_d  = pend_empty_q ? '0 : fold;
          out_err_d   = pend_empty_q ? empty_err_q : (count_q != decl_q);
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      slot_q       <= '0;
      rem_q        <= '0;
      count_q      <= '0;
      decl_q       <= '0;
      tail_q       <= 1'b0;
      tcnt_q       <= '0;
      pend_last_q  <= 1'b0;
      pend_empty_q <= 1'b0;
      empty_err_q  <= 1'b0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      slot_q       <= slot_d;
      rem_q        <= rem_d;
      count_q      <= count_d;
      decl_q       <= decl_d;
      tail_q       <= tail_d;
      tcnt_q       <= tcnt_d;
      pend_last_q  <= pend_last_d;
      pend_empty_q <= pend_empty_d;
      empty_err_q  <= empty_err_d;
      idx_q        <= idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_hash_q <= out_hash_d;
    out_err_q  <= out_err_d;
  end

  sharx_tail_mem #(
    .DEPTH(TAIL_DEPTH)
  ) u_tail_mem (
    .clk_i    (clk_i),
    .wr_en_i  (mem_wr_en),
    .wr_addr_i(mem_wr_addr),
    .wr_data_i(in_byte),
    .rd_en_i  (mem_rd_en),
    .rd_addr_i(mem_rd_addr),
    .rd_data_o(mem_rd_data)
  );

  sharx_arx_unit u_arx_unit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .chunk_wr_i (chunk_wr),
    .fold_byte_i(mem_rd_data),
    .fold_o     (fold)
  );

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_hash_q;
  assign m_axis_tuser[0] = out_err_q;

endmodule

FILE: rtl/core/sharx_tail_mem.sv
// ---------------------------------------------------------------------------
// sharx_tail_mem: tail byte store
// Single write port, single read port, read data registered.
// ---------------------------------------------------------------------------
module sharx_tail_mem #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [7:0]               wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [7:0]               rd_data_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/core/sharx_arx_unit.sv
// ---------------------------------------------------------------------------
// sharx_arx_unit: mixing state and fold datapath
// Holds a/b/h, the fold value and the chunk bytes; one start, add, mix or fold step per command.
// ---------------------------------------------------------------------------
module sharx_arx_unit import sharx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  arx_cmd_t    cmd_i,
  input  chunk_wr_t   chunk_wr_i,
  input  logic [7:0]  fold_byte_i,
  output logic [31:0] fold_o
);

  logic [CHUNK_LEN-1:0][7:0] chunk_q;
  logic [31:0] a_q, a_d, b_q, b_d, h_q, h_d;
  logic [31:0] f_q, f_d;
  logic [31:0] w0, w1, w2;

  // little-endian words
  assign w0 = chunk_q[3:0];
  assign w1 = chunk_q[7:4];
  assign w2 = chunk_q[11:8];

  always_comb begin
    a_d = a_q;
    b_d = b_q;
    h_d = h_q;
    f_d = f_q;
    unique case (cmd_i.op)
      OP_START: begin
        a_d = '0;
        b_d = '0;
        h_d = cmd_i.len;
      end
      OP_ADD: begin
        a_d = a_q + w0;
        b_d = b_q + w1;
        h_d = h_q + w2;
      end
      OP_MIX_A:     a_d = (a_q ^ h_q) - rotr32(h_q, ROT_A);
      OP_MIX_B:     b_d = (b_q ^ a_q) - rotr32(a_q, ROT_B);
      OP_MIX_H:     h_d = (h_q ^ b_q) - rotr32(b_q, ROT_H);
      OP_FOLD_LOAD: f_d = h_q;
      OP_FOLD_STEP: f_d = f_q ^ ((f_q << FOLD_SHL) + (f_q >> FOLD_SHR) + {24'd0, fold_byte_i});
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
      b_q <= '0;
      h_q <= '0;
    end else begin
      a_q <= a_d;
      b_q <= b_d;
      h_q <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    f_q <= f_d;
    if (chunk_wr_i.en) begin
      chunk_q[chunk_wr_i.slot] <= chunk_wr_i.data;
    end
  end

  assign fold_o = f_q;

endmodule

FILE: rtl/core/sharx_checker.sv
// ---------------------------------------------------------------------------
// sharx_checker: port-level checks on the string hash
// Watches both stream channels over time; bound to the top level below.
// ---------------------------------------------------------------------------
module sharx_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  logic s_acc;

  assign s_acc = s_axis_tvalid && s_axis_tready;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // a result leaves only by handshake
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(m_axis_tvalid) |-> $past(m_axis_tready))
    else $error("result dropped without handshake");

  // an empty string with a free output gives hash 0
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && s_axis_tuser[1] && (!m_axis_tvalid || m_axis_tready) |=>
      ##1 (m_axis_tvalid && (m_axis_tdata == 32'd0)))
    else $error("empty string did not give zero hash");

  // the final byte of a string always starts the fold, so input pauses
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && s_axis_tlast && !s_axis_tuser[1] |=> !s_axis_tready)
    else $error("input taken right after a final byte");

endmodule

bind string_hash_arx_prefix_top sharx_checker u_sharx_checker (.*);

FILE: tb/sv/string_hash_arx_prefix_top_tb.sv
// ---------------------------------------------------------------------------
// string_hash_arx_prefix_top_tb: self-checking bench for the streaming hash
// Streams byte requests into the block with random gaps and random result
// back-pressure. A local model of the ARX prefix mix and the shift-add-xor
// tail fold predicts each hash and length flag. Results are checked in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module string_hash_arx_prefix_top_tb;
  import sharx_pkg::*;

  localparam int unsigned TAIL_DEPTH  = 32;
  localparam int unsigned RANDOM_REQS = 1950;
  localparam int unsigned STALL_MAX   = 18;
  localparam int unsigned IDLE_LIMIT  = 1000;
  localparam int unsigned DRAIN_WAIT  = 60;

  typedef struct {
    logic [7:0]  data;
    logic [31:0] len;
    logic        first;
    logic        last;
    logic        empty;
    int unsigned gap;
    bit          drain;
  } byte_req_t;

  typedef struct {
    logic [31:0] hash;
    logic        length_error;
  } hash_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;  // [7:0] data_byte, [39:8] string_length
  logic [1:0]  s_axis_tuser  = '0;  // [0] first_item, [1] empty_string
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [31:0] hash_value
  logic [0:0]  m_axis_tuser;        // [0] length_error

  // model state
  logic [31:0] arx_a        = '0;
  logic [31:0] arx_b        = '0;
  logic [31:0] arx_h        = '0;
  logic [7:0]  chunk_buf [CHUNK_LEN]  = '{default: '0};
  logic [7:0]  tail_buf  [TAIL_DEPTH] = '{default: '0};
  logic [31:0] bytes_seen   = '0;
  logic [31:0] declared_len = '0;
  logic [31:0] prefix_len   = '0;

  byte_req_t    byte_reqs_q[$];
  hash_result_t hash_expect_q[$];
  logic         hashes_outstanding = 1'b0;

  int unsigned gap_left      = 0;
  int unsigned stall_left    = 0;
  bit          smooth_rx     = 1'b0;
  int unsigned quiet_left    = 0;
  bit          drain_next    = 1'b0;
  int unsigned idle_cycles   = 0;
  int unsigned fail_count    = 0;
  int unsigned reqs_taken    = 0;
  int unsigned hashes_seen   = 0;
  int unsigned flagged_seen  = 0;
  int unsigned chunks_mixed  = 0;

  string_hash_arx_prefix_top #(
    .TAIL_DEPTH(TAIL_DEPTH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned s);
    return (x >> s) | (x << (32 - s));
  endfunction

  function automatic logic [31:0] chunk_word(input int unsigned base);
    return {chunk_buf[base + 3], chunk_buf[base + 2], chunk_buf[base + 1], chunk_buf[base]};
  endfunction

  function automatic void mix_chunk_arx();
    arx_a = arx_a + chunk_word(0);
    arx_b = arx_b + chunk_word(4);
    arx_h = arx_h + chunk_word(8);
    arx_a = arx_a ^ arx_h;
    arx_a = arx_a - ror32(arx_h, ROT_A);
    arx_b = arx_b ^ arx_a;
    arx_b = arx_b - ror32(arx_a, ROT_B);
    arx_h = arx_h ^ arx_b;
    arx_h = arx_h - ror32(arx_b, ROT_H);
    chunks_mixed++;
  endfunction

  function automatic void restart_string(input logic [31:0] len);
    arx_a        = '0;
    arx_b        = '0;
    arx_h        = len;
    bytes_seen   = '0;
    declared_len = len;
    if (len < PREFIX_LIMIT) prefix_len = '0;
    else prefix_len = ((len - PREFIX_LIMIT) / CHUNK_LEN + 1) * CHUNK_LEN;
  endfunction

  // Takes one accepted request; queues the hash it produces, if any.
  function automatic void hash_absorb(input logic [7:0] d, input logic [31:0] len,
                                      input logic first, input logic last,
                                      input logic empty);
    logic [31:0]  pos;
    logic [31:0]  h;
    logic [31:0]  n;
    hash_result_t res;
    if (empty) begin
      restart_string('0);
      res.hash         = '0;
      res.length_error = (len != 0);
      hash_expect_q.push_back(res);
      return;
    end
    if (first) restart_string(len);
    pos = bytes_seen;
    if (pos < prefix_len) begin
      chunk_buf[pos % CHUNK_LEN] = d;
      if (pos % CHUNK_LEN == CHUNK_LEN - 1) mix_chunk_arx();
    end else if (pos - prefix_len < TAIL_DEPTH) begin
      tail_buf[pos - prefix_len] = d;
    end
    if (bytes_seen != 32'hFFFF_FFFF) bytes_seen++;
    if (!last) return;
    h = arx_h;
    n = '0;
    if (bytes_seen > prefix_len) begin
      n = bytes_seen - prefix_len;
      if (n > TAIL_DEPTH) n = TAIL_DEPTH;
    end
    // fold walks the tail backwards
    for (int i = n; i > 0; i--)
      h = h ^ ((h << FOLD_SHL) + (h >> FOLD_SHR) + {24'd0, tail_buf[i - 1]});
    res.hash         = h;
    res.length_error = (bytes_seen != declared_len);
    hash_expect_q.push_back(res);
  endfunction

  task automatic queue_req(input logic [7:0] d, input logic [31:0] len, input logic first,
                           input logic last, input logic empty);
    byte_req_t r;
    r.data  = d;
    r.len   = len;
    r.first = first;
    r.last  = last;
    r.empty = empty;
    r.drain = drain_next;
    drain_next = 1'b0;
    if (quiet_left != 0) begin
      quiet_left--;
      r.gap = 0;
    end else begin
      r.gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, STALL_MAX);
      if ($urandom_range(0, 39) == 0) quiet_left = 30;
    end
    byte_reqs_q.push_back(r);
  endtask

  // count bytes, first with declared len if with_first; count 0: an empty request
  task automatic queue_string(input logic [31:0] len, input int unsigned count,
                              input bit with_first);
    bit is_first;
    if (count == 0) begin
      queue_req(8'($urandom_range(0, 255)), len, 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 1'b1);
      return;
    end
    for (int unsigned i = 0; i < count; i++) begin
      is_first = with_first && (i == 0);
      queue_req(8'($urandom_range(0, 255)), is_first ? len : $urandom, is_first,
                i == count - 1, 1'b0);
    end
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin : feed
    byte_req_t req;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      s_axis_tlast  <= 1'b0;
      gap_left      <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left != 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left      <= gap_left - 1;
      end else if (byte_reqs_q.size() != 0 &&
                   !(byte_reqs_q[0].drain && (s_axis_tvalid || hashes_outstanding))) begin
        req = byte_reqs_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {req.len, req.data};
        s_axis_tuser  <= {req.empty, req.first};
        s_axis_tlast  <= req.last;
        gap_left      <= req.gap;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result back-pressure, with calm stretches now and then
  always @(posedge clk_i or negedge rst_ni) begin : rx_pace
    int unsigned stall;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= (stall_left == 1);
    end else if (m_axis_tvalid && m_axis_tready) begin
      stall = smooth_rx ? 0 : $urandom_range(0, STALL_MAX);
      if ($urandom_range(0, 15) == 0) smooth_rx <= !smooth_rx;
      stall_left    <= stall;
      m_axis_tready <= (stall == 0);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // monitor: predicts on accepted requests, checks accepted results
  always @(posedge clk_i or negedge rst_ni) begin : observe
    hash_result_t want;
    if (!rst_ni) begin
      hashes_outstanding <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        hash_absorb(s_axis_tdata[7:0], s_axis_tdata[39:8], s_axis_tuser[0], s_axis_tlast,
                    s_axis_tuser[1]);
        reqs_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        hashes_seen++;
        if (m_axis_tuser[0]) flagged_seen++;
        if (hash_expect_q.size() == 0) begin
          $error("unexpected result: hash_value %08h length_error %0b",
                 m_axis_tdata, m_axis_tuser[0]);
          fail_count++;
        end else begin
          want = hash_expect_q.pop_front();
          if (m_axis_tdata !== want.hash) begin
            $error("hash_value: expected %08h, got %08h", want.hash, m_axis_tdata);
            fail_count++;
          end
          if (m_axis_tuser[0] !== want.length_error) begin
            $error("length_error: expected %0b, got %0b", want.length_error, m_axis_tuser[0]);
            fail_count++;
          end
        end
      end
      hashes_outstanding <= (hash_expect_q.size() != 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: %0d cycles without a transfer", IDLE_LIMIT);
        $display("[string_hash_arx_prefix_top] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int unsigned kind;
    int unsigned len;
    int unsigned count;
    int unsigned total;

    // directed: missing first marker right after reset
    queue_string('0, 2, 1'b0);
    queue_req(8'hFF, 32'd0, 1'b0, 1'b0, 1'b1);
    queue_req(8'h00, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
    queue_req(8'hFF, 32'd1, 1'b1, 1'b1, 1'b0);
    queue_req(8'h00, 32'd1, 1'b1, 1'b1, 1'b0);
    queue_req(8'h5A, 32'd0, 1'b1, 1'b1, 1'b0);
    queue_string(32'd3, 2, 1'b1);
    // chunk never completes: whole string sits in the prefix region
    queue_string(32'hFFFF_FFFF, 3, 1'b1);
    // bytes after a result carry on with the same string
    queue_string('0, 1, 1'b0);
    drain_next = 1'b1;
    queue_string(32'd2, 2, 1'b1);

    total = byte_reqs_q.size() + RANDOM_REQS;
    while (byte_reqs_q.size() < total) begin
      if ($urandom_range(0, 149) == 0) drain_next = 1'b1;
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        len = $urandom_range(1, 31);
        queue_string(len, len, 1'b1);
      end else if (kind < 70) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(91, 160) : $urandom_range(32, 90);
        queue_string(len, len, 1'b1);
      end else if (kind < 78) begin
        len   = $urandom_range(0, 70);
        count = $urandom_range(1, 75);
        if (count == len) count++;
        queue_string(len, count, 1'b1);
      end else if (kind < 82) begin
        queue_string($urandom, $urandom_range(1, 20), 1'b1);
      end else if (kind < 87) begin
        // overrun past the tail store
        queue_string($urandom_range(0, 31), $urandom_range(33, 48), 1'b1);
      end else if (kind < 91) begin
        queue_string(($urandom_range(0, 1) == 0) ? 32'd0 : $urandom, 0, 1'b1);
      end else if (kind < 95) begin
        queue_string('0, $urandom_range(1, 6), 1'b0);
      end else begin
        queue_req(8'($urandom_range(0, 255)), $urandom, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'b0);
      end
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (byte_reqs_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (hash_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (hash_expect_q.size() != 0) begin
      $error("%0d expected results never arrived", hash_expect_q.size());
      fail_count++;
    end

    $display("Streamed %0d byte requests; %0d hashes checked, %0d flagged a length error.",
             reqs_taken, hashes_seen, flagged_seen);
    $display("Model mixed %0d prefix chunks along the way.", chunks_mixed);
    if (fail_count == 0)
      $display("[string_hash_arx_prefix_top] OK");
    else
      $display("[string_hash_arx_prefix_top] ERROR");
    $finish;
  end

endmodule
